// File: src/ppr_pkg.sv
// ----------------------------------------------------------------------------
// ppr_pkg
// Shared constants, tables and types of the point plane rotator: angle
// reduction constants, CORDIC arctangent table and the point record.
// ----------------------------------------------------------------------------
package ppr_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int ITERS         = (CORDIC_STAGES < 30) ? CORDIC_STAGES : 30;

  localparam int CW = 33;
  localparam logic signed [CW-1:0] GAIN_INIT = 33'sd652032874;

  localparam logic signed [17:0] DEG360  = 18'sd46080;
  localparam logic signed [17:0] DEG720  = 18'sd92160;
  localparam logic [16:0]        RECIP_I = 17'd93206;
  localparam logic [26:0]        RECIP_F = 27'd101408978;
  localparam int                 RECIP_SH = 27;

  localparam logic [29:0] ATAN_TAB [30] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465,  30'd10679838,  30'd5340245,   30'd2670163,  30'd1335087,
    30'd667544,    30'd333772,    30'd166886,    30'd83443,    30'd41722,
    30'd20861,     30'd10430,     30'd5215,      30'd2608,     30'd1304,
    30'd652,       30'd326,       30'd163,       30'd81,       30'd41,
    30'd20,        30'd10,        30'd5,         30'd3,        30'd1
  };

  typedef struct packed {
    logic               func;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_t;

endpackage

// File: src/ppr_angle.sv
// ----------------------------------------------------------------------------
// ppr_angle
// Four-stage angle front end: reduce degrees modulo 360, scale to a 32-bit
// binary angle by reciprocal multiplication, fold into [-90, +90] degrees.
// ----------------------------------------------------------------------------
module ppr_angle (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [16:0]  angle_deg,
  input  ppr_pkg::point_t     in_pt,
  output logic                out_valid,
  output logic signed [31:0]  t_out,
  output logic                neg_out,
  output ppr_pkg::point_t     out_pt
);

  logic                vld_a, vld_b, vld_c;
  logic [15:0]         a;
  logic [31:0]         p_int;
  logic [42:0]         p_frac;
  logic [31:0]         t_raw;
  ppr_pkg::point_t     pt_a, pt_b, pt_c;

  logic signed [17:0]  deg_ext;
  logic signed [17:0]  a_next;
  logic signed [32:0]  t_ext;
  logic signed [32:0]  t_next;
  logic                neg_next;

  always_comb begin
    deg_ext = 18'(angle_deg);
    if (deg_ext < -ppr_pkg::DEG360) begin
      a_next = deg_ext + ppr_pkg::DEG720;
    end else if (deg_ext < 18'sd0) begin
      a_next = deg_ext + ppr_pkg::DEG360;
    end else if (deg_ext >= ppr_pkg::DEG360) begin
      a_next = deg_ext - ppr_pkg::DEG360;
    end else begin
      a_next = deg_ext;
    end
  end

  always_comb begin
    t_ext    = 33'($signed(t_raw));
    neg_next = 1'b0;
    t_next   = t_ext;
    if (t_ext > 33'sd1073741824) begin
      t_next   = t_ext - 33'sd2147483648;
      neg_next = 1'b1;
    end else if (t_ext < -33'sd1073741824) begin
      t_next   = t_ext + 33'sd2147483648;
      neg_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a     <= 1'b0;
      vld_b     <= 1'b0;
      vld_c     <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld_a     <= in_valid;
      vld_b     <= vld_a;
      vld_c     <= vld_b;
      out_valid <= vld_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a       <= a_next[15:0];
      pt_a    <= in_pt;
      p_int   <= 32'(a * ppr_pkg::RECIP_I);
      p_frac  <= 43'(a * ppr_pkg::RECIP_F);
      pt_b    <= pt_a;
      t_raw   <= p_int + 32'(p_frac >> ppr_pkg::RECIP_SH);
      pt_c    <= pt_b;
      t_out   <= t_next[31:0];
      neg_out <= neg_next;
      out_pt  <= pt_c;
    end
  end

endmodule

// File: src/ppr_cordic.sv
// ----------------------------------------------------------------------------
// ppr_cordic
// Unrolled rotation-mode CORDIC, one register stage per iteration, then a
// stage that applies the quadrant fold sign to cosine and sine.
// ----------------------------------------------------------------------------
module ppr_cordic (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [31:0]            t_in,
  input  logic                          neg_in,
  input  ppr_pkg::point_t               in_pt,
  output logic                          out_valid,
  output logic signed [ppr_pkg::CW-1:0] cos_out,
  output logic signed [ppr_pkg::CW-1:0] sin_out,
  output ppr_pkg::point_t               out_pt
);

  localparam int N  = ppr_pkg::ITERS;
  localparam int CW = ppr_pkg::CW;

  logic [N:0]           vld;
  logic [N:0]           ngs;
  logic signed [CW-1:0] xs [N+1];
  logic signed [CW-1:0] ys [N+1];
  logic signed [CW-1:0] zs [N+1];
  ppr_pkg::point_t      pts [N+1];

  assign vld[0] = in_valid;
  assign ngs[0] = neg_in;
  assign xs[0]  = ppr_pkg::GAIN_INIT;
  assign ys[0]  = '0;
  assign zs[0]  = CW'(t_in);
  assign pts[0] = in_pt;

  for (genvar i = 0; i < N; i++) begin : g_iter
    logic signed [CW-1:0] xsh, ysh, ang;

    assign xsh = xs[i] >>> i;
    assign ysh = ys[i] >>> i;
    assign ang = $signed(CW'(ppr_pkg::ATAN_TAB[i]));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!zs[i][CW-1]) begin
          xs[i+1] <= xs[i] - ysh;
          ys[i+1] <= ys[i] + xsh;
          zs[i+1] <= zs[i] - ang;
        end else begin
          xs[i+1] <= xs[i] + ysh;
          ys[i+1] <= ys[i] - xsh;
          zs[i+1] <= zs[i] + ang;
        end
        ngs[i+1] <= ngs[i];
        pts[i+1] <= pts[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_out <= ngs[N] ? -xs[N] : xs[N];
      sin_out <= ngs[N] ? -ys[N] : ys[N];
      out_pt  <= pts[N];
    end
  end

endmodule

// File: src/point_plane_rotator_unit.sv
// ----------------------------------------------------------------------------
// point_plane_rotator_unit
// Rotates a Q16.16 point in the X-Y plane (func 0) or the Y-Z plane (func 1)
// by an angle in 1/128 degree units, with saturated Q16.16 results.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while the output is not stalled; the fully unrolled CORDIC pipeline sets it.
// A stalled output holds every stage in place.
// Reset clears all valid bits; data registers are not reset.
module point_plane_rotator_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               func,
  input  logic signed [31:0] x_in,
  input  logic signed [31:0] y_in,
  input  logic signed [31:0] z_in,
  input  logic signed [16:0] angle_deg,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] x_out,
  output logic signed [31:0] y_out,
  output logic signed [31:0] z_out
);

  localparam int CW = ppr_pkg::CW;
  localparam int PW = 32 + CW;
  localparam int SW = PW + 1;
  localparam logic signed [SW-1:0] RND = SW'(64'sd536870912);

  logic                 en;
  ppr_pkg::point_t      pt_in, pt_ang, pt_cor, pt_mul;
  logic                 ang_valid, cor_valid, mul_valid;
  logic signed [31:0]   t_ang;
  logic                 neg_ang;
  logic signed [CW-1:0] co, si;
  logic signed [31:0]   p_sel, q_sel;
  logic signed [PW-1:0] pc, qs, ps, qc;
  logic signed [SW-1:0] sum_a, sum_b;

  function automatic logic signed [31:0] sat32(input logic signed [SW-31:0] v);
    if (v > (SW-30)'(64'sd2147483647)) begin
      return 32'sh7FFFFFFF;
    end else if (v < -(SW-30)'(64'sd2147483648)) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  assign en       = !out_valid || out_ready;
  assign in_ready = en && !rst;
  assign pt_in    = '{func: func, x: x_in, y: y_in, z: z_in};

  ppr_angle u_angle (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .angle_deg (angle_deg),
    .in_pt     (pt_in),
    .out_valid (ang_valid),
    .t_out     (t_ang),
    .neg_out   (neg_ang),
    .out_pt    (pt_ang)
  );

  ppr_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (ang_valid),
    .t_in      (t_ang),
    .neg_in    (neg_ang),
    .in_pt     (pt_ang),
    .out_valid (cor_valid),
    .cos_out   (co),
    .sin_out   (si),
    .out_pt    (pt_cor)
  );

  assign p_sel = pt_cor.func ? pt_cor.y : pt_cor.x;
  assign q_sel = pt_cor.func ? pt_cor.z : pt_cor.y;

  always_ff @(posedge clk) begin
    if (en) begin
      pc     <= p_sel * co;
      qs     <= q_sel * si;
      ps     <= p_sel * si;
      qc     <= q_sel * co;
      pt_mul <= pt_cor;
    end
  end

  assign sum_a = SW'(pc) - SW'(qs) + RND;
  assign sum_b = SW'(ps) + SW'(qc) + RND;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      mul_valid <= cor_valid;
      out_valid <= mul_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!pt_mul.func) begin
        x_out <= sat32(sum_a[SW-1:30]);
        y_out <= sat32(sum_b[SW-1:30]);
        z_out <= pt_mul.z;
      end else begin
        x_out <= pt_mul.x;
        y_out <= sat32(sum_a[SW-1:30]);
        z_out <= sat32(sum_b[SW-1:30]);
      end
    end
  end

endmodule

// File: src/ppr_checker.sv
// ----------------------------------------------------------------------------
// ppr_checker
// Port-level checks of the point plane rotator, bound to the top level.
// ----------------------------------------------------------------------------
module ppr_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               func,
  input logic signed [31:0] x_in,
  input logic signed [31:0] y_in,
  input logic signed [31:0] z_in,
  input logic signed [16:0] angle_deg,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] x_out,
  input logic signed [31:0] y_out,
  input logic signed [31:0] z_out
);

  a_ready_follows_stall: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not track output stall");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(x_out) && $stable(y_out) && $stable(z_out)))
    else $error("stalled output item changed");

  a_input_holds: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_ready) |=>
      (in_valid && $stable(func) && $stable(x_in) && $stable(y_in) &&
       $stable(z_in) && $stable(angle_deg)))
    else $error("waiting input item changed");

endmodule

bind point_plane_rotator_unit ppr_checker u_ppr_checker (.*);

// File: tb/sv/point_plane_rotator_unit_tb.sv
// ----------------------------------------------------------------------------
// point_plane_rotator_unit_tb
// Self-checking bench for the point plane rotator. A queue of directed and
// random points feeds a valid/ready driver with random gaps; a monitor with
// random and long stalls compares every rotated point, field by field, with
// a bit-exact CORDIC prediction of the X-Y and Y-Z plane rotations.
// ----------------------------------------------------------------------------
module point_plane_rotator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic FUNC_XY = 1'b0;
  localparam logic FUNC_YZ = 1'b1;

  localparam int     N_STAGES    = (ppr_pkg::CORDIC_STAGES < 30) ? ppr_pkg::CORDIC_STAGES : 30;
  localparam int     LATENCY     = ppr_pkg::CORDIC_STAGES + 7;
  localparam int     N_RANDOM    = 1700;
  localparam longint DEG_FULL    = 46080;
  localparam longint PI_BA       = 64'sd2147483648;
  localparam longint HALF_PI_BA  = 64'sd1073741824;
  localparam longint CORDIC_GAIN = 64'sd652032874;
  localparam longint ROUND_HALF  = 64'sd536870912;
  localparam longint SAT_HI      = 64'sd2147483647;
  localparam longint SAT_LO      = -64'sd2147483648;
  localparam logic signed [31:0] C_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] C_MIN = 32'sh80000000;
  localparam logic signed [31:0] ONE   = 32'sd65536;

  localparam longint ATAN_BA [30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1
  };

  typedef struct {
    ppr_pkg::point_t    pt;
    logic signed [16:0] angle;
    int unsigned        gap;
    bit                 drain;
  } rot_req_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } coords_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               func = FUNC_XY;
  logic signed [31:0] x_in = '0;
  logic signed [31:0] y_in = '0;
  logic signed [31:0] z_in = '0;
  logic signed [16:0] angle_deg = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] x_out;
  logic signed [31:0] y_out;
  logic signed [31:0] z_out;

  rot_req_t pending_points[$];
  coords_t  expected_coords[$];
  rot_req_t on_wire;
  int       n_total = 0;
  int       n_accepted = 0;
  int       n_results = 0;
  int       errors = 0;
  int       idle_cycles = 0;
  int       rx_stall = 0;
  int       rx_hold = 0;
  bit       rx_steady = 1'b0;

  point_plane_rotator_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .x_in      (x_in),
    .y_in      (y_in),
    .z_in      (z_in),
    .angle_deg (angle_deg),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .x_out     (x_out),
    .y_out     (y_out),
    .z_out     (z_out)
  );

  function automatic logic signed [31:0] round_sat(longint acc);
    longint r;
    r = (acc + ROUND_HALF) >>> 30;
    if (r > SAT_HI) r = SAT_HI;
    if (r < SAT_LO) r = SAT_LO;
    return r[31:0];
  endfunction

  function automatic coords_t rotate_point(ppr_pkg::point_t p, logic signed [16:0] ang);
    longint          a, t, cx, cy, nx, px, py, pz;
    longint unsigned ba;
    bit              flip;
    coords_t         r;
    a = longint'(ang) % DEG_FULL;
    if (a < 0) a += DEG_FULL;
    ba = a;
    ba = (ba << 32) / 64'd46080;
    t = longint'(ba);
    if (t >= PI_BA) t -= 2 * PI_BA;
    flip = 1'b0;
    if (t > HALF_PI_BA) begin
      t -= PI_BA;
      flip = 1'b1;
    end else if (t < -HALF_PI_BA) begin
      t += PI_BA;
      flip = 1'b1;
    end
    cx = CORDIC_GAIN;
    cy = 0;
    for (int i = 0; i < N_STAGES; i++) begin
      if (t >= 0) begin
        nx = cx - (cy >>> i);
        cy = cy + (cx >>> i);
        t -= ATAN_BA[i];
      end else begin
        nx = cx + (cy >>> i);
        cy = cy - (cx >>> i);
        t += ATAN_BA[i];
      end
      cx = nx;
    end
    if (flip) begin
      cx = -cx;
      cy = -cy;
    end
    px = longint'(p.x);
    py = longint'(p.y);
    pz = longint'(p.z);
    if (p.func == FUNC_XY) begin
      r.x = round_sat(px * cx - py * cy);
      r.y = round_sat(px * cy + py * cx);
      r.z = p.z;
    end else begin
      r.x = p.x;
      r.y = round_sat(py * cx - pz * cy);
      r.z = round_sat(py * cy + pz * cx);
    end
    return r;
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0, 1: return $urandom;
      2: return int'($urandom_range(0, 2097152)) - 1048576;
      3: return int'($urandom_range(0, 13107200)) - 6553600;
      default: begin
        case ($urandom_range(0, 4))
          0: return C_MAX;
          1: return C_MIN;
          2: return 32'sd0;
          3: return -32'sd1;
          default: return 32'sd1;
        endcase
      end
    endcase
  endfunction

  task automatic add_point(logic f, logic signed [31:0] x, logic signed [31:0] y,
                           logic signed [31:0] z, logic signed [16:0] ang,
                           int unsigned gap, bit drain);
    rot_req_t q;
    q.pt.func = f;
    q.pt.x = x;
    q.pt.y = y;
    q.pt.z = z;
    q.angle = ang;
    q.gap = gap;
    q.drain = drain;
    pending_points.push_back(q);
    n_total++;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end

  // driver: offer head item after its gap and any drain; hold it until taken
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      idle_cycles = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_coords.push_back(rotate_point(on_wire.pt, on_wire.angle));
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (pending_points.size() != 0 && idle_cycles >= int'(pending_points[0].gap) &&
            (!pending_points[0].drain || expected_coords.size() == 0)) begin
          on_wire = pending_points.pop_front();
          func      <= on_wire.pt.func;
          x_in      <= on_wire.pt.x;
          y_in      <= on_wire.pt.y;
          z_in      <= on_wire.pt.z;
          angle_deg <= on_wire.angle;
          in_valid  <= 1'b1;
          idle_cycles = 0;
        end else begin
          in_valid <= 1'b0;
          idle_cycles++;
        end
      end
    end
  end

  // monitor: check each item, then stall or hold off before the next one
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_stall = 0;
      rx_hold = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_coords.size() == 0) begin
          $display("%0t ns: unexpected item, actual %h %h %h", $time, x_out, y_out, z_out);
          errors++;
        end else begin
          coords_t want;
          want = expected_coords.pop_front();
          check_field("x_out", want.x, x_out);
          check_field("y_out", want.y, y_out);
          check_field("z_out", want.z, z_out);
        end
        n_results++;
        if (n_results % 128 == 0) rx_steady = !rx_steady;
        if (n_results == 500) rx_hold = 300;
        rx_stall = rx_steady ? 0 : $urandom_range(0, 3);
      end
      if (rx_hold != 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else if (rx_stall != 0) begin
        rx_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    logic               f;
    logic signed [16:0] ang;
    bit                 steady;
    int unsigned        gap;

    add_point(FUNC_XY, ONE, 32'sd0, 32'sd5, 17'sd0, 0, 1'b0);
    add_point(FUNC_XY, ONE, 32'sd0, 32'sd5, 17'sd11520, 0, 1'b0);
    add_point(FUNC_XY, ONE, ONE, -ONE, 17'sd23040, 1, 1'b0);
    add_point(FUNC_XY, ONE, -ONE, 32'sd7, 17'sd34560, 0, 1'b0);
    add_point(FUNC_YZ, 32'sd3, ONE, 32'sd0, 17'sd46080, 2, 1'b0);
    add_point(FUNC_YZ, C_MIN, C_MAX, C_MAX, 17'sd5760, 0, 1'b0);
    add_point(FUNC_XY, C_MIN, C_MIN, C_MAX, 17'sd5760, 0, 1'b0);
    add_point(FUNC_XY, C_MAX, C_MIN, C_MIN, -17'sd5760, 3, 1'b0);
    add_point(FUNC_YZ, 32'sh12345678, -32'sh0abcdef0, 32'sh7654321, -17'sd65536, 0, 1'b0);
    add_point(FUNC_XY, 32'sh0fedcba9, 32'sh01234567, -32'sd1, 17'sd65535, 0, 1'b0);
    add_point(FUNC_YZ, ONE, ONE, ONE, -17'sd1, 0, 1'b0);
    add_point(FUNC_XY, C_MAX, C_MAX, C_MAX, 17'sd1, 1, 1'b0);
    add_point(FUNC_YZ, 32'sd0, 32'sd0, 32'sd0, 17'sd0, 0, 1'b0);
    add_point(FUNC_XY, -32'sd1, -32'sd1, -32'sd1, -17'sd23040, 0, 1'b0);
    add_point(FUNC_YZ, C_MAX, C_MAX, C_MIN, 17'sd17280, 0, 1'b0);
    add_point(FUNC_XY, C_MIN, 32'sd0, C_MIN, 17'sd23040, 0, 1'b0);
    add_point(FUNC_YZ, C_MIN, 32'sd0, C_MIN, 17'sd11520, 2, 1'b0);
    add_point(FUNC_XY, 32'sd100, 32'sd200, 32'sd300, -17'sd46080, 0, 1'b0);
    add_point(FUNC_YZ, 32'sd100, ONE, -ONE, 17'sd11521, 0, 1'b0);
    add_point(FUNC_YZ, C_MAX, -ONE, C_MAX, 17'sd65535, 0, 1'b0);
    add_point(FUNC_XY, ONE, ONE, 32'sd0, 17'sd11519, 0, 1'b0);

    steady = 1'b0;
    for (int k = 0; k < N_RANDOM; k++) begin
      if (k % 64 == 0) steady = ($urandom_range(0, 2) == 0);
      f = $urandom_range(0, 1) ? FUNC_YZ : FUNC_XY;
      case ($urandom_range(0, 3))
        0, 1: ang = 17'($urandom);
        2: ang = 17'(int'($urandom_range(0, 10)) * 11520 - 57600 +
                     int'($urandom_range(0, 4)) - 2);
        default: ang = 17'(int'($urandom_range(0, 92160)) - 46080);
      endcase
      gap = steady ? 0 : $urandom_range(0, 3);
      add_point(f, rand_coord(), rand_coord(), rand_coord(), ang, gap,
                k == 0 || k == 600 || k == 1200);
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (n_accepted != n_total) @(posedge clk);
    while (expected_coords.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
